/* rtl/core/sgr_pkg.sv */
// ---------------------------------------------------------------------------
// sgr_pkg
// Types, character codes and attribute helpers for the SGR attribute decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

  localparam logic [7:0] CharEsc     = 8'h1B;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSemi    = 8'h3B;
  localparam logic [7:0] CharSgrEnd  = 8'h6D;  // 'm'
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;

  localparam logic [3:0] ColorDefault = 4'd8;
  localparam logic [7:0] AccMax       = 8'd255;

  // SGR codes
  localparam logic [7:0] SgrReset     = 8'd0;
  localparam logic [7:0] SgrBold      = 8'd1;
  localparam logic [7:0] SgrUnderline = 8'd4;
  localparam logic [7:0] SgrFgFirst   = 8'd30;
  localparam logic [7:0] SgrFgLast    = 8'd37;
  localparam logic [7:0] SgrFgDefault = 8'd39;
  localparam logic [7:0] SgrBgFirst   = 8'd40;
  localparam logic [7:0] SgrBgLast    = 8'd47;
  localparam logic [7:0] SgrBgDefault = 8'd49;

  typedef enum logic [1:0] {
    ST_TEXT      = 2'd0,
    ST_ESC_FIRST = 2'd1,
    ST_PARAMS    = 2'd2
  } scan_state_e;

  typedef enum logic [1:0] {
    PS_EMPTY    = 2'd0,  // nothing seen in this parameter
    PS_DIGITS   = 2'd1,  // gathering digits
    PS_TRAILING = 2'd2,  // digits, then other bytes
    PS_INVALID  = 2'd3   // started with a non-digit
  } param_status_e;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
    logic       bold;
    logic       underline;
  } attr_t;

  localparam attr_t AttrDefault = '{fg: ColorDefault, bg: ColorDefault,
                                    bold: 1'b0, underline: 1'b0};

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[CharZero:CharNine]});
  endfunction

  function automatic attr_t apply_sgr(input attr_t a, input logic [7:0] v);
    attr_t r;
    logic [7:0] fg_idx;
    logic [7:0] bg_idx;
    r      = a;
    fg_idx = v - SgrFgFirst;
    bg_idx = v - SgrBgFirst;
    if (v == SgrReset) begin
      r = AttrDefault;
    end else if (v == SgrBold) begin
      r.bold = 1'b1;
    end else if (v == SgrUnderline) begin
      r.underline = 1'b1;
    end else if (v inside {[SgrFgFirst:SgrFgLast]}) begin
      r.fg = fg_idx[3:0];
    end else if (v == SgrFgDefault) begin
      r.fg = ColorDefault;
    end else if (v inside {[SgrBgFirst:SgrBgLast]}) begin
      r.bg = bg_idx[3:0];
    end else if (v == SgrBgDefault) begin
      r.bg = ColorDefault;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ansi_sgr_attribute_decoder_core.sv */
// ---------------------------------------------------------------------------
// ansi_sgr_attribute_decoder_core
// Terminal byte stream decoder: passes text bytes through tagged with the
// current SGR attributes and swallows escape sequences.
// ---------------------------------------------------------------------------
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  in      | in_valid_i, in_stall_o,        | request in
//          | byte_in_i                      |
//  out     | out_valid_o, out_stall_i, kind,| request out
//          | char, fg, bg, bold, underline  |
//
//  One byte per cycle while the result is not stalled: input register, one
//  level of decode logic, result register. A byte's result is loaded as the
//  byte leaves the input register. Bytes that produce no result (ESC and
//  sequence bytes) still take a slot. Reset clears the scanner and restores
//  default attributes. A stalled result stalls the input only when a byte
//  is waiting in the input register and the result register is full.
// ---------------------------------------------------------------------------
`default_nettype none

module ansi_sgr_attribute_decoder_core
  import sgr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [7:0]      char_out_o,
  output logic [3:0]      fg_out_o,
  output logic [3:0]      bg_out_o,
  output logic            bold_out_o,
  output logic            underline_out_o
);

  // input register
  logic          in_vld_q;
  logic [7:0]    byte_q;
  logic          advance;
  logic          in_accept;

  // scanner state
  scan_state_e   state_q, state_d;
  param_status_e pstat_q, pstat_d;
  logic [7:0]    pval_q, pval_d;
  logic          seen_sep_q, seen_sep_d;
  attr_t         attr_q, attr_d;
  attr_t         pend_q, pend_d;

  // result register
  logic          out_vld_q, out_vld_d;
  logic          kind_q;
  logic [7:0]    char_q;
  attr_t         out_attr_q;
  logic          emit;

  logic          letter;
  logic [11:0]   acc;
  attr_t         final_attr;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign letter     = is_letter(byte_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= byte_in_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_TEXT: begin
        if (byte_q == CharEsc) state_d = ST_ESC_FIRST;
      end
      ST_ESC_FIRST: begin
        state_d = letter ? ST_TEXT : ST_PARAMS;
      end
      ST_PARAMS: begin
        if (letter) state_d = ST_TEXT;
      end
      default: state_d = ST_TEXT;
    endcase
  end

  // parameter datapath and result
  always_comb begin
    pstat_d    = pstat_q;
    pval_d     = pval_q;
    seen_sep_d = seen_sep_q;
    attr_d     = attr_q;
    pend_d     = pend_q;
    emit       = 1'b0;
    acc        = ({4'b0, pval_q} << 3) + ({4'b0, pval_q} << 1) + {8'b0, byte_q[3:0]};

    // value in force when the sequence ends with 'm'
    final_attr = pend_q;
    if (pstat_q == PS_DIGITS || pstat_q == PS_TRAILING) begin
      final_attr = apply_sgr(pend_q, pval_q);
    end else if (pstat_q == PS_EMPTY && !seen_sep_q) begin
      final_attr = apply_sgr(pend_q, SgrReset);
    end

    case (state_q)
      ST_TEXT: begin
        if (byte_q == CharEsc) begin
          seen_sep_d = 1'b0;
          pval_d     = '0;
          pstat_d    = PS_EMPTY;
          pend_d     = attr_q;
        end else begin
          emit = 1'b1;
        end
      end
      ST_ESC_FIRST: begin
      end
      ST_PARAMS: begin
        if (letter) begin
          if (byte_q == CharSgrEnd) begin
            attr_d = final_attr;
            pend_d = final_attr;
          end else begin
            pend_d = attr_q;
          end
          pval_d     = '0;
          pstat_d    = PS_EMPTY;
          seen_sep_d = 1'b0;
        end else if (byte_q == CharSemi) begin
          if (pstat_q == PS_EMPTY) begin
            pend_d = apply_sgr(pend_q, SgrReset);
          end else if (pstat_q != PS_INVALID) begin
            pend_d = apply_sgr(pend_q, pval_q);
          end
          pval_d     = '0;
          pstat_d    = PS_EMPTY;
          seen_sep_d = 1'b1;
        end else if (is_digit(byte_q)) begin
          if (pstat_q == PS_EMPTY || pstat_q == PS_DIGITS) begin
            pval_d  = (acc > {4'b0, AccMax}) ? AccMax : acc[7:0];
            pstat_d = PS_DIGITS;
          end
        end else begin
          if (pstat_q == PS_EMPTY) begin
            pstat_d = PS_INVALID;
          end else if (pstat_q == PS_DIGITS) begin
            pstat_d = PS_TRAILING;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_TEXT;
      pstat_q    <= PS_EMPTY;
      pval_q     <= '0;
      seen_sep_q <= 1'b0;
      attr_q     <= AttrDefault;
      pend_q     <= AttrDefault;
    end else if (advance) begin
      state_q    <= state_d;
      pstat_q    <= pstat_d;
      pval_q     <= pval_d;
      seen_sep_q <= seen_sep_d;
      attr_q     <= attr_d;
      pend_q     <= pend_d;
    end
  end

  assign out_vld_d = advance ? emit : (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q     <= (byte_q == CharNewline);
      char_q     <= byte_q;
      out_attr_q <= attr_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = kind_q;
  assign char_out_o      = char_q;
  assign fg_out_o        = out_attr_q.fg;
  assign bg_out_o        = out_attr_q.bg;
  assign bold_out_o      = out_attr_q.bold;
  assign underline_out_o = out_attr_q.underline;

`ifndef SYNTHESIS
  a_kind_matches_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (kind_q == (char_q == CharNewline)))
    else $error("kind does not match newline byte");

  a_no_esc_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (char_q != CharEsc))
    else $error("ESC byte leaked to output");

  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_attr_q.fg <= ColorDefault && out_attr_q.bg <= ColorDefault))
    else $error("color index out of range");

  a_pend_synced_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEXT) |-> (pend_q == attr_q))
    else $error("pending attributes differ from committed outside a sequence");

  a_stall_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(char_q) && $stable(out_attr_q)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
